### rtl/smb_pkg.sv
// Shared constants for the stereo meter ballistics block: register map,
// reset values and zone codes. No dependencies.
package smb_pkg;

  // Gain factors are unsigned Q0.16.
  localparam int GAIN_BITS = 16;

  // Register indexes, taken from byte address bits [4:2].
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_RELEASE = 3'd1;
  localparam logic [2:0] REG_HOLD    = 3'd2;
  localparam logic [2:0] REG_FALL    = 3'd3;
  localparam logic [2:0] REG_GREEN   = 3'd4;
  localparam logic [2:0] REG_YELLOW  = 3'd5;

  // Reset values before truncation to each register's width.
  localparam logic [31:0] RST_ATTACK  = 32'd9830;
  localparam logic [31:0] RST_RELEASE = 32'd5243;
  localparam logic [31:0] RST_HOLD    = 32'd90;
  localparam logic [31:0] RST_FALL    = 32'd3277;
  localparam logic [31:0] RST_GREEN   = 32'd39322;
  localparam logic [31:0] RST_YELLOW  = 32'd52429;

  // Color zone codes.
  localparam logic [1:0] ZONE_SILENT = 2'd0;
  localparam logic [1:0] ZONE_GREEN  = 2'd1;
  localparam logic [1:0] ZONE_YELLOW = 2'd2;
  localparam logic [1:0] ZONE_RED    = 2'd3;

endpackage

### rtl/stereo_meter_ballistics.sv
// Top level of the stereo meter ballistics block: stream ports, register
// file, input and result registers. Depends on smb_pkg and smb_channel.
//
//  channel   signals                      payload
//  in        in_tvalid/in_tready/in_tdata  one meter tick, both levels
//  out       out_tvalid/out_tready/out_tdata smoothed, peaks, zones
//  cfg       APB write/read, pready high  six registers at 4*index
//
// An item is taken into the input register; both channels are then updated
// from it and the result register is loaded once that register is free.
// One item per cycle is sustained while the output is not stalled, with a
// single multiply per channel between those registers. A stalled result
// holds; the input register still takes one more item behind it. Synchronous
// active-low reset clears the channel state and restores the register defaults.
module stereo_meter_ballistics #(
  parameter int LEVEL_BITS = 16,
  parameter int HOLD_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // left_in, right_in (from bit 0 up), zero padding
  input  logic [((2*LEVEL_BITS+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // left_smooth, right_smooth, left_hold, right_hold, left_zone,
  // right_zone (from bit 0 up), zero padding
  output logic [((4*LEVEL_BITS+4+7)/8)*8-1:0] out_tdata,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int IN_BITS  = 2 * LEVEL_BITS;
  localparam int OUT_BITS = 4 * LEVEL_BITS + 4;
  localparam int GB       = smb_pkg::GAIN_BITS;

  // Configuration registers.
  logic [GB-1:0]         attack_r;
  logic [GB-1:0]         release_r;
  logic [HOLD_BITS-1:0]  hold_r;
  logic [LEVEL_BITS-1:0] fall_r;
  logic [LEVEL_BITS-1:0] green_r;
  logic [LEVEL_BITS-1:0] yellow_r;

  // Channel state.
  logic [LEVEL_BITS-1:0] left_avg_r, right_avg_r, left_peak_r, right_peak_r;
  logic [HOLD_BITS-1:0]  left_count_r, right_count_r;
  logic [LEVEL_BITS-1:0] left_avg_nxt, right_avg_nxt, left_peak_nxt, right_peak_nxt;
  logic [HOLD_BITS-1:0]  left_count_nxt, right_count_nxt;
  logic [1:0]            left_zone, right_zone;

  // Pipeline registers.
  logic                  s1_valid_r;
  logic [LEVEL_BITS-1:0] s1_left_r, s1_right_r;
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_data_r;

  logic cfg_wr;
  logic advance;
  logic fire;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= GB'(smb_pkg::RST_ATTACK);
      release_r <= GB'(smb_pkg::RST_RELEASE);
      hold_r    <= HOLD_BITS'(smb_pkg::RST_HOLD);
      fall_r    <= LEVEL_BITS'(smb_pkg::RST_FALL);
      green_r   <= LEVEL_BITS'(smb_pkg::RST_GREEN);
      yellow_r  <= LEVEL_BITS'(smb_pkg::RST_YELLOW);
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        smb_pkg::REG_ATTACK:  attack_r  <= cfg_pwdata[GB-1:0];
        smb_pkg::REG_RELEASE: release_r <= cfg_pwdata[GB-1:0];
        smb_pkg::REG_HOLD:    hold_r    <= cfg_pwdata[HOLD_BITS-1:0];
        smb_pkg::REG_FALL:    fall_r    <= cfg_pwdata[LEVEL_BITS-1:0];
        smb_pkg::REG_GREEN:   green_r   <= cfg_pwdata[LEVEL_BITS-1:0];
        smb_pkg::REG_YELLOW:  yellow_r  <= cfg_pwdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      smb_pkg::REG_ATTACK:  cfg_prdata = 32'(attack_r);
      smb_pkg::REG_RELEASE: cfg_prdata = 32'(release_r);
      smb_pkg::REG_HOLD:    cfg_prdata = 32'(hold_r);
      smb_pkg::REG_FALL:    cfg_prdata = 32'(fall_r);
      smb_pkg::REG_GREEN:   cfg_prdata = 32'(green_r);
      smb_pkg::REG_YELLOW:  cfg_prdata = 32'(yellow_r);
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // The result register frees up when it is empty or being taken.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_left_r  <= in_tdata[LEVEL_BITS-1:0];
      s1_right_r <= in_tdata[IN_BITS-1:LEVEL_BITS];
    end
  end

  smb_channel #(.LEVEL_BITS(LEVEL_BITS), .HOLD_BITS(HOLD_BITS)) u_left (
    .lvl          (s1_left_r),
    .avg          (left_avg_r),
    .peak         (left_peak_r),
    .count        (left_count_r),
    .attack_gain  (attack_r),
    .release_gain (release_r),
    .hold_ticks   (hold_r),
    .fall_step    (fall_r),
    .green_limit  (green_r),
    .yellow_limit (yellow_r),
    .avg_nxt      (left_avg_nxt),
    .peak_nxt     (left_peak_nxt),
    .count_nxt    (left_count_nxt),
    .zone         (left_zone)
  );

  smb_channel #(.LEVEL_BITS(LEVEL_BITS), .HOLD_BITS(HOLD_BITS)) u_right (
    .lvl          (s1_right_r),
    .avg          (right_avg_r),
    .peak         (right_peak_r),
    .count        (right_count_r),
    .attack_gain  (attack_r),
    .release_gain (release_r),
    .hold_ticks   (hold_r),
    .fall_step    (fall_r),
    .green_limit  (green_r),
    .yellow_limit (yellow_r),
    .avg_nxt      (right_avg_nxt),
    .peak_nxt     (right_peak_nxt),
    .count_nxt    (right_count_nxt),
    .zone         (right_zone)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_avg_r    <= '0;
      right_avg_r   <= '0;
      left_peak_r   <= '0;
      right_peak_r  <= '0;
      left_count_r  <= '0;
      right_count_r <= '0;
    end else if (fire) begin
      left_avg_r    <= left_avg_nxt;
      right_avg_r   <= right_avg_nxt;
      left_peak_r   <= left_peak_nxt;
      right_peak_r  <= right_peak_nxt;
      left_count_r  <= left_count_nxt;
      right_count_r <= right_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {right_zone, left_zone, right_peak_nxt, left_peak_nxt,
                     right_avg_nxt, left_avg_nxt};
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                 = '0;
    out_tdata[OUT_BITS-1:0]   = out_data_r;
  end

endmodule

### rtl/smb_channel.sv
// Next-state logic of one meter channel: attack/release smoothing, peak
// hold with falloff and the color zone. Depends on smb_pkg.
module smb_channel #(
  parameter int LEVEL_BITS = 16,
  parameter int HOLD_BITS  = 10
) (
  input  logic [LEVEL_BITS-1:0]        lvl,
  input  logic [LEVEL_BITS-1:0]        avg,
  input  logic [LEVEL_BITS-1:0]        peak,
  input  logic [HOLD_BITS-1:0]         count,
  input  logic [smb_pkg::GAIN_BITS-1:0] attack_gain,
  input  logic [smb_pkg::GAIN_BITS-1:0] release_gain,
  input  logic [HOLD_BITS-1:0]         hold_ticks,
  input  logic [LEVEL_BITS-1:0]        fall_step,
  input  logic [LEVEL_BITS-1:0]        green_limit,
  input  logic [LEVEL_BITS-1:0]        yellow_limit,
  output logic [LEVEL_BITS-1:0]        avg_nxt,
  output logic [LEVEL_BITS-1:0]        peak_nxt,
  output logic [HOLD_BITS-1:0]         count_nxt,
  output logic [1:0]                   zone
);

  localparam int GB = smb_pkg::GAIN_BITS;
  localparam int PB = LEVEL_BITS + GB;

  logic                    rise;
  logic                    not_below;
  logic [GB-1:0]           gain;
  logic [LEVEL_BITS-1:0]   diff;
  logic [PB-1:0]           prod;
  logic [LEVEL_BITS-1:0]   step_floor;
  logic [LEVEL_BITS-1:0]   step_ceil;

  always_comb begin
    rise      = lvl > avg;
    not_below = lvl >= avg;
    gain      = rise ? attack_gain : release_gain;
    diff      = not_below ? (lvl - avg) : (avg - lvl);
    prod      = PB'(diff) * PB'(gain);
    step_floor = prod[PB-1:GB];
    // A falling move is the floor of a negative quotient, so the magnitude
    // rounds up. It never exceeds the distance, so no saturation is needed.
    step_ceil  = step_floor + LEVEL_BITS'(|prod[GB-1:0]);
    avg_nxt    = not_below ? (avg + step_floor) : (avg - step_ceil);
  end

  always_comb begin
    peak_nxt  = peak;
    count_nxt = count;
    if (lvl > peak) begin
      peak_nxt  = lvl;
      count_nxt = hold_ticks;
    end else if (count != '0) begin
      count_nxt = count - HOLD_BITS'(1);
    end else begin
      peak_nxt = (peak > fall_step) ? (peak - fall_step) : '0;
    end
  end

  always_comb begin
    if (avg_nxt == '0) begin
      zone = smb_pkg::ZONE_SILENT;
    end else if (avg_nxt > yellow_limit) begin
      zone = smb_pkg::ZONE_RED;
    end else if (avg_nxt > green_limit) begin
      zone = smb_pkg::ZONE_YELLOW;
    end else begin
      zone = smb_pkg::ZONE_GREEN;
    end
  end

endmodule

### sim/tb.sv
// Self-checking testbench for stereo_meter_ballistics: meter ticks in, one
// reading out per tick, checked against a cycle-free predictor kept here.
// Depends on smb_pkg and the stereo_meter_ballistics RTL.
module tb;

  localparam int QUIET_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [15:0] left_lvl;
    logic [15:0] right_lvl;
  } meter_tick_t;

  typedef struct packed {
    logic [15:0] avg;
    logic [15:0] peak;
    logic [9:0]  count;
  } meter_chan_t;

  typedef struct packed {
    logic [15:0] left_smooth;
    logic [15:0] right_smooth;
    logic [15:0] left_hold;
    logic [15:0] right_hold;
    logic [1:0]  left_zone;
    logic [1:0]  right_zone;
  } meter_reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // left_in, right_in (from bit 0 up)
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // left_smooth, right_smooth, left_hold, right_hold, left_zone,
  // right_zone (from bit 0 up), zero padding
  logic [71:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  stereo_meter_ballistics dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Register mirror and channel state of the predictor.
  logic [15:0] attack_gain, release_gain, fall_step, green_limit, yellow_limit;
  logic [9:0]  hold_ticks;
  meter_chan_t left_chan = '0;
  meter_chan_t right_chan = '0;

  meter_tick_t    tick_q[$];
  meter_reading_t reading_q[$];

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  int  holdoff_req = 0;
  int  holdoff_seen = 0;
  int  holdoff_left = 0;
  bit  no_idle = 1'b0;
  meter_tick_t    next_tick;
  meter_reading_t want;

  initial begin
    forever #4 clk = ~clk;
  end

  // One-pole step toward the level; a falling step rounds toward minus infinity.
  function automatic logic [15:0] smooth_step(logic [15:0] avg, logic [15:0] lvl);
    logic [15:0] gain;
    logic [32:0] prod;
    logic [32:0] delta;
    gain = (lvl > avg) ? attack_gain : release_gain;
    if (lvl >= avg) begin
      prod  = {17'd0, 16'(lvl - avg)} * {17'd0, gain};
      delta = prod >> 16;
      return avg + delta[15:0];
    end
    prod  = {17'd0, 16'(avg - lvl)} * {17'd0, gain} + 33'h0FFFF;
    delta = prod >> 16;
    return (delta > {17'd0, avg}) ? 16'd0 : avg - delta[15:0];
  endfunction

  function automatic meter_chan_t chan_update(meter_chan_t c, logic [15:0] lvl);
    meter_chan_t n;
    n = c;
    n.avg = smooth_step(c.avg, lvl);
    if (lvl > c.peak) begin
      n.peak  = lvl;
      n.count = hold_ticks;
    end else if (c.count != 10'd0) begin
      n.count = c.count - 10'd1;
    end else begin
      n.peak = (c.peak > fall_step) ? c.peak - fall_step : 16'd0;
    end
    return n;
  endfunction

  // Red is tested before yellow, so limits out of order still give one zone.
  function automatic logic [1:0] zone_of_level(logic [15:0] v);
    if (v == 16'd0) return smb_pkg::ZONE_SILENT;
    if (v > yellow_limit) return smb_pkg::ZONE_RED;
    if (v > green_limit) return smb_pkg::ZONE_YELLOW;
    return smb_pkg::ZONE_GREEN;
  endfunction

  task automatic predict_reading(input logic [15:0] l, input logic [15:0] r);
    meter_reading_t m;
    left_chan  = chan_update(left_chan, l);
    right_chan = chan_update(right_chan, r);
    m.left_smooth  = left_chan.avg;
    m.right_smooth = right_chan.avg;
    m.left_hold    = left_chan.peak;
    m.right_hold   = right_chan.peak;
    m.left_zone    = zone_of_level(left_chan.avg);
    m.right_zone   = zone_of_level(right_chan.avg);
    reading_q.push_back(m);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    if (mismatch_count < 40)
      $display("mismatch: %s on result %0d, got %h, expected %h",
               what, results_seen, got, exp_val);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      smb_pkg::REG_ATTACK:  attack_gain  = value[15:0];
      smb_pkg::REG_RELEASE: release_gain = value[15:0];
      smb_pkg::REG_HOLD:    hold_ticks   = value[9:0];
      smb_pkg::REG_FALL:    fall_step    = value[15:0];
      smb_pkg::REG_GREEN:   green_limit  = value[15:0];
      smb_pkg::REG_YELLOW:  yellow_limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_tick(input logic [15:0] l, input logic [15:0] r);
    tick_q.push_back('{left_lvl: l, right_lvl: r});
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || in_tvalid || reading_q.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h0000_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic load_random_settings();
    logic [31:0] hold_val;
    case ($urandom_range(0, 3))
      0: hold_val = 32'd0;
      1: hold_val = $urandom();
      default: hold_val = $urandom_range(1, 24);
    endcase
    write_reg(smb_pkg::REG_ATTACK, pick_value());
    write_reg(smb_pkg::REG_RELEASE, pick_value());
    write_reg(smb_pkg::REG_HOLD, hold_val);
    write_reg(smb_pkg::REG_FALL, ($urandom_range(0, 3) == 0) ? pick_value()
                                                   : 32'($urandom_range(0, 3000)));
    write_reg(smb_pkg::REG_GREEN, pick_value());
    write_reg(smb_pkg::REG_YELLOW, pick_value());
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
  endtask

  // Runs of related ticks: decaying envelopes, steady tones, silence,
  // full-scale bursts, and plain noise.
  task automatic queue_random_runs(input int remaining);
    int kind, len;
    logic [15:0] lbase, rbase, lstep, rstep;
    while (remaining > 0) begin
      kind  = $urandom_range(0, 9);
      len   = $urandom_range(3, 40);
      lbase = 16'($urandom());
      rbase = 16'($urandom());
      lstep = 16'($urandom_range(0, 4000));
      rstep = 16'($urandom_range(0, 4000));
      for (int k = 0; k < len && remaining > 0; k++) begin
        case (kind)
          0, 1, 2, 3: begin
            queue_tick(lbase, rbase);
            lbase = (lbase > lstep) ? lbase - lstep : 16'd0;
            rbase = (rbase > rstep) ? rbase - rstep : 16'd0;
          end
          4, 5: queue_tick(lbase ^ 16'($urandom_range(0, 7)),
                           rbase ^ 16'($urandom_range(0, 7)));
          6: queue_tick(16'd0, 16'd0);
          7: queue_tick(16'hFFFF, $urandom_range(0, 1) ? 16'hFFFF : rbase);
          default: queue_tick(16'($urandom()), 16'($urandom()));
        endcase
        remaining--;
      end
    end
  endtask

  // Input driver: a new tick is offered once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_reading(in_tdata[15:0], in_tdata[31:16]);
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
          next_tick = tick_q.pop_front();
          in_tdata  <= {next_tick.right_lvl, next_tick.left_lvl};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_tready   <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (reading_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata[15:0], 16'd0);
      end else begin
        want = reading_q.pop_front();
        if (out_tdata[15:0] !== want.left_smooth)
          report_mismatch("left_smooth", out_tdata[15:0], want.left_smooth);
        if (out_tdata[31:16] !== want.right_smooth)
          report_mismatch("right_smooth", out_tdata[31:16], want.right_smooth);
        if (out_tdata[47:32] !== want.left_hold)
          report_mismatch("left_hold", out_tdata[47:32], want.left_hold);
        if (out_tdata[63:48] !== want.right_hold)
          report_mismatch("right_hold", out_tdata[63:48], want.right_hold);
        if (out_tdata[65:64] !== want.left_zone)
          report_mismatch("left_zone", 16'(out_tdata[65:64]), 16'(want.left_zone));
        if (out_tdata[67:66] !== want.right_zone)
          report_mismatch("right_zone", 16'(out_tdata[67:66]), 16'(want.right_zone));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("** stereo_meter_ballistics: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    attack_gain  = smb_pkg::RST_ATTACK[15:0];
    release_gain = smb_pkg::RST_RELEASE[15:0];
    hold_ticks   = smb_pkg::RST_HOLD[9:0];
    fall_step    = smb_pkg::RST_FALL[15:0];
    green_limit  = smb_pkg::RST_GREEN[15:0];
    yellow_limit = smb_pkg::RST_YELLOW[15:0];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes, zone boundaries and alternating bit patterns.
    queue_tick(16'd0, 16'd0);
    queue_tick(16'hFFFF, 16'd0);
    queue_tick(16'hFFFF, 16'hFFFF);
    queue_tick(16'd0, 16'hFFFF);
    queue_tick(16'd39322, 16'd52429);
    queue_tick(16'd39323, 16'd52430);
    queue_tick(16'hAAAA, 16'h5555);
    queue_tick(16'h5555, 16'hAAAA);
    queue_tick(16'd1, 16'd1);
    wait_drained();

    // Zero gains freeze the smoothed levels; no hold and a full-scale fall
    // drop the peak to zero at once.
    write_reg(smb_pkg::REG_ATTACK, 32'd0);
    write_reg(smb_pkg::REG_RELEASE, 32'd0);
    write_reg(smb_pkg::REG_HOLD, 32'd0);
    write_reg(smb_pkg::REG_FALL, 32'h0000_FFFF);
    write_reg(smb_pkg::REG_GREEN, 32'd0);
    write_reg(smb_pkg::REG_YELLOW, 32'd0);
    queue_tick(16'hFFFF, 16'd0);
    queue_tick(16'd0, 16'hFFFF);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd12345, 16'd1);
    wait_drained();

    // Full gains, longest hold, no fall.
    write_reg(smb_pkg::REG_ATTACK, 32'h0000_FFFF);
    write_reg(smb_pkg::REG_RELEASE, 32'h0000_FFFF);
    write_reg(smb_pkg::REG_HOLD, 32'h0000_03FF);
    write_reg(smb_pkg::REG_FALL, 32'd0);
    write_reg(smb_pkg::REG_GREEN, 32'h0000_FFFF);
    write_reg(smb_pkg::REG_YELLOW, 32'h0000_FFFF);
    queue_tick(16'hFFFF, 16'hFFFF);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd1, 16'hFFFE);
    wait_drained();

    // Yellow limit below green, bits above the width set in the gain, hold and
    // fall registers, and writes to unused addresses.
    write_reg(smb_pkg::REG_ATTACK, 32'hFFFF_8000);
    write_reg(smb_pkg::REG_RELEASE, 32'h1234_4000);
    write_reg(smb_pkg::REG_HOLD, 32'hFFFF_FC02);
    write_reg(smb_pkg::REG_FALL, 32'hABCD_1000);
    write_reg(smb_pkg::REG_GREEN, 32'd50000);
    write_reg(smb_pkg::REG_YELLOW, 32'd20000);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_0001);
    queue_tick(16'd20000, 16'd20001);
    queue_tick(16'd50000, 16'd50001);
    queue_tick(16'd60000, 16'd30000);
    queue_tick(16'd60000, 16'd30000);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd0, 16'd0);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      load_random_settings();
      no_idle <= (phase == 1);
      queue_random_runs(400);
      // The input keeps offering ticks while results are held back.
      if (phase == 3) holdoff_req <= holdoff_req + 1;
      wait_drained();
    end
    no_idle <= 1'b0;

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && reading_q.size() == 0) begin
      $display("** stereo_meter_ballistics: PASSED **");
    end else begin
      $display("** stereo_meter_ballistics: FAILED **");
    end
    $finish;
  end

endmodule
